// ===== hw/rtl/rptw_pkg.sv =====
// Shared types, widths and codes of the radix page table walker.
package rptw_pkg;

	// Table geometry: each node holds 512 entries indexed by 9 bits of the page number.
	// The frame count must be a power of two: a frame number selects a node by its low bits.
	localparam int IDX_W       = 9;
	localparam int VPN_W       = 45;
	localparam int NUM_W       = 52;
	localparam int ENTRY_W     = NUM_W + 1;
	localparam int MAX_LEVELS  = 6;
	localparam int LEVEL_W     = 3;
	localparam int VPN_EXT_W   = MAX_LEVELS * IDX_W;
	localparam int VPN_PAD_W   = VPN_EXT_W - VPN_W;

	// Defaults for the top-level parameters
	localparam int DEF_FRAMES  = 64;
	localparam int DEF_LEVELS  = 5;
	localparam int DEF_ADDR_W  = 15;

	// Configuration port
	localparam int ROOT_W      = 6;
	localparam int FFREE_W     = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;
	localparam logic [FFREE_W-1:0]   FFREE_RST      = 7'd1;

	// Request operation and result status codes
	localparam logic FUNC_QUERY  = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic             func;
		logic [VPN_W-1:0] vpn;
		logic [NUM_W-1:0] ppn;
		logic             unmap;
	} req_t;

	typedef struct packed {
		logic             mapped;
		logic [NUM_W-1:0] ppn_out;
		logic             status;
	} rsp_t;

	// Configuration state handed from the register block to the walker
	typedef struct packed {
		logic [ROOT_W-1:0]  root_frame;
		logic               ffree_load;
		logic [FFREE_W-1:0] ffree_value;
	} cfg_t;

endpackage

// ===== hw/rtl/radix_page_table_walker.sv =====
// Radix page table walker: configuration registers, frame store and walk sequencer.
// The walker takes one request at a time: req_stall stays high until its result is handed to the output.
// Each level reads the store in a read state, then evaluates the entry in an evaluate state that may write back.
// Reset: a clearing pass zeroes the store, with req_stall high.
// Reset also sets root_frame to 0 and the frame allocator to 1; configuration writes are always taken.
module radix_page_table_walker #(
	parameter int FRAMES = rptw_pkg::DEF_FRAMES,
	parameter int LEVELS = rptw_pkg::DEF_LEVELS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  rptw_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output rptw_pkg::rsp_t                  rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rptw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rptw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rptw_pkg::*;

	localparam int ADDR_W = $clog2(FRAMES) + IDX_W;

	logic [ROOT_W-1:0]  root_frame_q;
	logic               cfg_write;
	cfg_t               cfg;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	// Take every configuration transaction
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// Hold the root frame register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_frame_q <= '0;
		end else if (cfg_write && cfg_index == CFG_ROOT_FRAME) begin
			root_frame_q <= cfg_data[ROOT_W-1:0];
		end
	end

	assign cfg.root_frame  = root_frame_q;
	assign cfg.ffree_load  = cfg_write && (cfg_index == CFG_FIRST_FREE);
	assign cfg.ffree_value = cfg_data[FFREE_W-1:0];

	rptw_frame_mem #(
		.ADDR_W (ADDR_W)
	) u_frame_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rptw_walker #(
		.FRAMES (FRAMES),
		.LEVELS (LEVELS)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

// ===== hw/rtl/rptw_frame_mem.sv =====
// Frame store: synchronous RAM with one write port and one registered read port.
module rptw_frame_mem #(
	parameter int ADDR_W = rptw_pkg::DEF_ADDR_W
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [ADDR_W-1:0]            waddr,
	input  logic [rptw_pkg::ENTRY_W-1:0] wdata,
	input  logic [ADDR_W-1:0]            raddr,
	output logic [rptw_pkg::ENTRY_W-1:0] rdata
);
	import rptw_pkg::*;

	logic [ENTRY_W-1:0] mem [2**ADDR_W];

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/rptw_walker.sv =====
// Walk sequencer: clears the store, walks the levels, allocates nodes and registers the result.
module rptw_walker #(
	parameter int FRAMES = rptw_pkg::DEF_FRAMES,
	parameter int LEVELS = rptw_pkg::DEF_LEVELS,
	localparam int ADDR_W = $clog2(FRAMES) + rptw_pkg::IDX_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rptw_pkg::cfg_t               cfg,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  rptw_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output rptw_pkg::rsp_t               rsp,
	output logic                         mem_we,
	output logic [ADDR_W-1:0]            mem_waddr,
	output logic [rptw_pkg::ENTRY_W-1:0] mem_wdata,
	output logic [ADDR_W-1:0]            mem_raddr,
	input  logic [rptw_pkg::ENTRY_W-1:0] mem_rdata
);
	import rptw_pkg::*;

	localparam int FB = $clog2(FRAMES);
	localparam int CW = (FB + 1 > FFREE_W) ? FB + 1 : FFREE_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic [CW-1:0]      cnt_q;
	logic               rsp_valid_q;
	req_t               req_q;
	logic [LEVEL_W-1:0] level_q;
	logic [FB-1:0]      base_q;
	rsp_t               res_q;
	rsp_t               rsp_q;

	logic [VPN_EXT_W-1:0] vpn_ext;
	logic [IDX_W-1:0]     idx;
	logic [ADDR_W-1:0]    slot_addr;
	logic                 ent_valid;
	logic [NUM_W-1:0]     ent_num;
	logic                 is_leaf;
	logic                 cnt_full;
	logic                 out_free;

	logic               ev_write;
	logic [ENTRY_W-1:0] ev_wdata;
	logic               ev_finish;
	logic               ev_alloc;
	logic [FB-1:0]      ev_next_base;
	rsp_t               ev_res;

	// Select the index of the current level and form the slot address
	assign vpn_ext   = {{VPN_PAD_W{1'b0}}, req_q.vpn};
	assign idx       = vpn_ext[level_q * IDX_W +: IDX_W];
	assign slot_addr = {base_q, idx};
	assign ent_valid = mem_rdata[0];
	assign ent_num   = mem_rdata[ENTRY_W-1:1];
	assign is_leaf   = (level_q == '0);
	assign cnt_full  = (cnt_q >= CW'(FRAMES));
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Decide what the entry just read means for this transaction
	always_comb begin
		ev_write     = 1'b0;
		ev_wdata     = mem_rdata;
		ev_finish    = 1'b0;
		ev_alloc     = 1'b0;
		ev_next_base = ent_num[FB-1:0];
		ev_res       = '{mapped: 1'b0, ppn_out: '0, status: STATUS_OK};
		if (req_q.func == FUNC_QUERY) begin
			if (!ent_valid) begin
				ev_finish = 1'b1;
			end else if (is_leaf) begin
				ev_finish      = 1'b1;
				ev_res.mapped  = 1'b1;
				ev_res.ppn_out = ent_num;
			end
		end else begin
			ev_res.mapped = !req_q.unmap;
			if (is_leaf) begin
				ev_finish = 1'b1;
				ev_write  = 1'b1;
				ev_wdata  = req_q.unmap ? {ent_num, 1'b0} : {req_q.ppn, 1'b1};
			end else if (!ent_valid) begin
				if (req_q.unmap) begin
					ev_finish = 1'b1;
				end else if (cnt_full) begin
					ev_finish     = 1'b1;
					ev_res.status = STATUS_FULL;
				end else begin
					// Hand out the next frame and link it into this slot
					ev_alloc     = 1'b1;
					ev_write     = 1'b1;
					ev_wdata     = ENTRY_W'({cnt_q, 1'b1});
					ev_next_base = cnt_q[FB-1:0];
				end
			end
		end
	end

	// Drive the store: sweep with zeros after reset, else write back the evaluated slot
	always_comb begin
		mem_raddr = slot_addr;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == ST_EVAL) && ev_write;
			mem_waddr = slot_addr;
			mem_wdata = ev_wdata;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (ev_finish) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Step the allocator; a write of its start register reloads it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(FFREE_RST);
		end else if (cfg.ffree_load) begin
			cnt_q <= CW'(cfg.ffree_value);
		end else if (state_q == ST_EVAL && ev_alloc) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Raise the output valid when a finished walk hands over, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold the request, the walk position and the result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q   <= req;
			level_q <= LEVEL_W'(LEVELS - 1);
			base_q  <= FB'(cfg.root_frame);
		end
		if (state_q == ST_EVAL) begin
			if (ev_finish) begin
				res_q <= ev_res;
			end else begin
				level_q <= level_q - LEVEL_W'(1);
				base_q  <= ev_next_base;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	// The store is written only by the clearing sweep or by an evaluated update
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_EVAL))
		else $error("store written outside clear or evaluate");

	// A query never modifies the table
	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && req_q.func == FUNC_QUERY) |-> !mem_we)
		else $error("query wrote the store");

	// The allocator only moves forward unless reloaded
	a_cnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.ffree_load |=> (cnt_q >= $past(cnt_q)))
		else $error("frame allocator went backwards");

	// A result appears only after a finished walk
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised without a finished walk");

endmodule
